[sv/chorus_pkg.sv]
// ============================================================================
// chorus_pkg
// Shared types, constants and register codes of the LFO-modulated chorus.
// ============================================================================
package chorus_pkg;

    // Default sizes handed down from the top level
    localparam int DELAY_LEN_DEF    = 2048;
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Fixed field widths
    localparam int SINE_W     = 16;   // Q1.15 sine
    localparam int WET_W      = 7;
    localparam int DLY_CFG_W  = 19;   // Q8 delay settings
    localparam int STEP_W     = 32;   // phase accumulator
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [WET_W-1:0]     WET_RST   = 7'd50;
    localparam logic [DLY_CFG_W-1:0] BASE_RST  = 19'd86016;
    localparam logic [DLY_CFG_W-1:0] DEPTH_RST = 19'd24576;
    localparam logic [STEP_W-1:0]    STEP_RST  = 32'd89478;

    // Mix constants
    localparam logic [WET_W-1:0] WET_FULL   = 7'd100;
    localparam int               ROUND_HALF = 50;
    // floor(v/100) == (v * DIV100_MUL) >> DIV100_SHIFT for all v < 2^31
    localparam logic [31:0]      DIV100_MUL   = 32'd2748779070;
    localparam int               DIV100_SHIFT = 38;

    // Delay arithmetic: Q8 setting times Q15 sine gives Q23 samples
    localparam int DLY_FRAC  = 23;
    localparam int DLY_ROUND = 4194304;
    localparam int PROD_W    = DLY_CFG_W + 1 + SINE_W;  // depth * sine, signed
    localparam int T_W       = PROD_W + 2;              // tap distance sum, signed
    localparam int D_W       = T_W - 1 - DLY_FRAC;      // whole samples

    // Sine polynomial, Q30
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint SIN_C1  = 64'sd1686629716;
    localparam longint SIN_C3  = -64'sd693598674;
    localparam longint SIN_C5  = 64'sd85569306;
    localparam longint SIN_C7  = -64'sd5026997;
    localparam longint SIN_C9  = 64'sd172272;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_WET   = 2'd0,
        REG_BASE  = 2'd1,
        REG_DEPTH = 2'd2,
        REG_STEP  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [WET_W-1:0]     wet_percent;
        logic [DLY_CFG_W-1:0] base_delay;
        logic [DLY_CFG_W-1:0] depth;
        logic [STEP_W-1:0]    phase_step;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINE,
        ST_PROD,
        ST_DLY,
        ST_ADDR,
        ST_WRITE,
        ST_SUM,
        ST_DIV
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take input word, step LFO
        logic sine_rd;   // sine ROM read
        logic prod;      // depth * sine
        logic dly;       // tap distance, rounded and clamped
        logic rd;        // delay line read
        logic wr;        // delay line write, mix products
        logic sum;       // mix sum, magnitude
        logic out_load;  // divide by 100, load output register
    } cmd_t;

    // Top level to controller
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } stat_t;

endpackage

[sv/chorus_ctrl.sv]
// ============================================================================
// chorus_ctrl
// Sequencer of the chorus: steps one word through the datapath stages.
// ============================================================================
module chorus_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  chorus_pkg::stat_t stat,
    output logic              in_ready,
    output chorus_pkg::cmd_t  cmd
);

    chorus_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= chorus_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            chorus_pkg::ST_IDLE: begin
                if (stat.in_valid) begin
                    state_next = chorus_pkg::ST_SINE;
                end
            end
            chorus_pkg::ST_SINE:  state_next = chorus_pkg::ST_PROD;
            chorus_pkg::ST_PROD:  state_next = chorus_pkg::ST_DLY;
            chorus_pkg::ST_DLY:   state_next = chorus_pkg::ST_ADDR;
            chorus_pkg::ST_ADDR:  state_next = chorus_pkg::ST_WRITE;
            chorus_pkg::ST_WRITE: state_next = chorus_pkg::ST_SUM;
            chorus_pkg::ST_SUM:   state_next = chorus_pkg::ST_DIV;
            chorus_pkg::ST_DIV: begin
                // hold the result until the output register frees up
                if (stat.out_free) begin
                    state_next = chorus_pkg::ST_IDLE;
                end
            end
            default: state_next = chorus_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            chorus_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = stat.in_valid;
            end
            chorus_pkg::ST_SINE:  cmd.sine_rd = 1'b1;
            chorus_pkg::ST_PROD:  cmd.prod    = 1'b1;
            chorus_pkg::ST_DLY:   cmd.dly     = 1'b1;
            chorus_pkg::ST_ADDR:  cmd.rd      = 1'b1;
            chorus_pkg::ST_WRITE: cmd.wr      = 1'b1;
            chorus_pkg::ST_SUM:   cmd.sum     = 1'b1;
            chorus_pkg::ST_DIV:   cmd.out_load = stat.out_free;
            default: begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

    // Checks
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.in_valid && in_ready) |=> (state_reg == chorus_pkg::ST_SINE))
        else $error("accepted word did not start the sequence");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded into a full output register");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule

[sv/chorus_dp.sv]
// ============================================================================
// chorus_dp
// Chorus datapath: LFO phase and sine ROM, tap distance, delay line RAM,
// dry/wet mix and rounding divide by 100.
// ============================================================================
module chorus_dp #(
    parameter int DELAY_LEN    = chorus_pkg::DELAY_LEN_DEF,
    parameter int SINE_ENTRIES = chorus_pkg::SINE_ENTRIES_DEF,
    parameter int SAMPLE_BITS  = chorus_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  chorus_pkg::cmd_t       cmd,
    input  chorus_pkg::cfg_t       cfg,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic [SAMPLE_BITS-1:0] sample_out
);

    localparam int AW    = $clog2(DELAY_LEN);
    localparam int IW    = $clog2(SINE_ENTRIES);
    localparam int MIX_W = SAMPLE_BITS + 8;   // 8-bit signed gain times sample
    localparam int SUM_W = MIX_W + 1;
    localparam int MAG_W = SAMPLE_BITS + 7;   // |sum| + 50 < 2^31 up to 24 bits

    typedef logic signed [chorus_pkg::SINE_W-1:0] sine_rom_t [SINE_ENTRIES];

    // Q30 product truncated toward zero
    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) / chorus_pkg::Q30_ONE;
    endfunction

    // Sine table from the quarter-wave odd polynomial, built at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    p;
        longint    quad;
        longint    u;
        longint    u2;
        longint    acc;
        longint    s;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            p    = (longint'(i) <<< 32) / SINE_ENTRIES;
            quad = p >>> 30;
            u    = p & 64'sh3FFF_FFFF;
            if (quad == 1 || quad == 3) begin
                u = chorus_pkg::Q30_ONE - u;
            end
            u2  = q30_mul(u, u);
            acc = chorus_pkg::SIN_C9;
            acc = chorus_pkg::SIN_C7 + q30_mul(acc, u2);
            acc = chorus_pkg::SIN_C5 + q30_mul(acc, u2);
            acc = chorus_pkg::SIN_C3 + q30_mul(acc, u2);
            acc = chorus_pkg::SIN_C1 + q30_mul(acc, u2);
            s   = q30_mul(acc, u);
            if (s < 0) begin
                s = 0;
            end
            s = (s + 16384) / 32768;
            if (s > 32767) begin
                s = 32767;
            end
            rom[i] = chorus_pkg::SINE_W'((quad >= 2) ? -s : s);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Control state
    logic [chorus_pkg::STEP_W-1:0] phase_reg;
    logic [AW-1:0]                 wp_reg;
    logic                          wrapped_reg;

    // Payload registers
    logic signed [SAMPLE_BITS-1:0]          x_reg;
    logic [IW-1:0]                          idx_reg;
    logic signed [chorus_pkg::SINE_W-1:0]   sine_reg;
    logic signed [chorus_pkg::PROD_W-1:0]   prod_reg;
    logic [AW-1:0]                          dly_reg;
    logic signed [SAMPLE_BITS-1:0]          tap_raw_reg;
    logic                                   tap_vld_reg;
    logic signed [MIX_W-1:0]                pd_reg;
    logic signed [MIX_W-1:0]                pw_reg;
    logic [MAG_W-1:0]                       mag_reg;
    logic                                   neg_reg;

    // Delay line
    logic signed [SAMPLE_BITS-1:0] mem [DELAY_LEN];

    // LFO table index: (phase * entries) >> 32
    logic [63:0] idx_prod;
    assign idx_prod = 64'(phase_reg) * 64'(SINE_ENTRIES);

    // Tap distance in whole samples, round half up, clamped to the line
    logic signed [chorus_pkg::T_W-1:0] t_sum;
    logic [chorus_pkg::D_W-1:0]        d_whole;
    logic [31:0]                       d_ext;
    logic [AW-1:0]                     dly_next;

    assign t_sum = $signed({{(chorus_pkg::T_W - chorus_pkg::DLY_CFG_W - 15){1'b0}},
                            cfg.base_delay, 15'b0})
                 + chorus_pkg::T_W'(prod_reg)
                 + chorus_pkg::T_W'(chorus_pkg::DLY_ROUND);
    assign d_whole = t_sum[chorus_pkg::T_W-2:chorus_pkg::DLY_FRAC];
    assign d_ext   = 32'(d_whole);

    always_comb begin
        if (t_sum[chorus_pkg::T_W-1]) begin
            dly_next = '0;
        end else if (d_ext > 32'(DELAY_LEN - 1)) begin
            dly_next = AW'(DELAY_LEN - 1);
        end else begin
            dly_next = AW'(d_ext);
        end
    end

    // Read address: write position minus distance, circular
    logic [AW:0]   rd_diff;
    logic [AW-1:0] rd_addr;
    assign rd_diff = {1'b0, wp_reg} - {1'b0, dly_reg};
    assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW + 1)'(DELAY_LEN)) : rd_diff[AW-1:0];

    // Entries below the write position, or all after one wrap, hold samples
    logic rd_written;
    assign rd_written = wrapped_reg || (rd_addr < wp_reg);

    // Mix gains
    logic [chorus_pkg::WET_W-1:0]  wet;
    logic [chorus_pkg::WET_W-1:0]  dry;
    logic signed [SAMPLE_BITS-1:0] tap;
    assign wet = (cfg.wet_percent > chorus_pkg::WET_FULL) ? chorus_pkg::WET_FULL
                                                          : cfg.wet_percent;
    assign dry = chorus_pkg::WET_FULL - wet;
    assign tap = tap_vld_reg ? tap_raw_reg : '0;

    // Sum and magnitude
    logic signed [SUM_W-1:0] mix_sum;
    logic [SUM_W-1:0]        mix_abs;
    assign mix_sum = SUM_W'(pd_reg) + SUM_W'(pw_reg);
    assign mix_abs = mix_sum[SUM_W-1] ? SUM_W'(-mix_sum) : SUM_W'(mix_sum);

    // Divide by 100 through the reciprocal, then restore the sign
    logic [63:0]            q_prod;
    logic [SAMPLE_BITS-1:0] q_mag;
    assign q_prod     = 64'(mag_reg) * 64'(chorus_pkg::DIV100_MUL);
    assign q_mag      = q_prod[chorus_pkg::DIV100_SHIFT +: SAMPLE_BITS];
    assign sample_out = neg_reg ? SAMPLE_BITS'(-q_mag) : q_mag;

    // LFO phase, write position and fill flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                phase_reg <= phase_reg + cfg.phase_step;
            end
            if (cmd.wr) begin
                if (wp_reg == AW'(DELAY_LEN - 1)) begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
        end
    end

    // Stage registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg   <= sample_in;
            idx_reg <= idx_prod[32 +: IW];
        end
        if (cmd.sine_rd) begin
            sine_reg <= SINE_ROM[idx_reg];
        end
        if (cmd.prod) begin
            prod_reg <= $signed({1'b0, cfg.depth}) * sine_reg;
        end
        if (cmd.dly) begin
            dly_reg <= dly_next;
        end
        if (cmd.rd) begin
            tap_vld_reg <= rd_written;
        end
        if (cmd.wr) begin
            pd_reg <= $signed({1'b0, dry}) * x_reg;
            pw_reg <= $signed({1'b0, wet}) * tap;
        end
        if (cmd.sum) begin
            mag_reg <= MAG_W'(mix_abs) + MAG_W'(chorus_pkg::ROUND_HALF);
            neg_reg <= mix_sum[SUM_W-1];
        end
    end

    // Delay line RAM, one port
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[wp_reg] <= x_reg;
        end
        if (cmd.rd) begin
            tap_raw_reg <= mem[rd_addr];
        end
    end

    // Checks
    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> (32'(rd_addr) < 32'(DELAY_LEN)))
        else $error("delay line read address out of range");

    a_dly_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> (32'(dly_reg) < 32'(DELAY_LEN)))
        else $error("tap distance beyond the delay line");

    a_wp_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |=> (wp_reg != $past(wp_reg)))
        else $error("write position did not advance after a write");

endmodule

[sv/lfo_modulated_delay_chorus.sv]
// ============================================================================
// lfo_modulated_delay_chorus
// Chorus effect: each sample is mixed with a tap from a circular delay line
// whose distance follows a sine LFO.
// ============================================================================
//
//  channel  | ports                     | word
//  ---------+---------------------------+--------------------------------
//  input    | s_tvalid s_tready s_tdata | sample_in, signed
//  output   | m_tvalid m_tready m_tdata | sample_out, signed
//  config   | APB psel .. prdata        | wet, base delay, depth, step
//
//  After acceptance a sample passes the sequencer's steps: sine ROM read, delay
//  multiply, tap address, single-port delay line read and write, mix and
//  reciprocal divide, then the result enters the output register; the next
//  word is taken only once the sequencer is back in idle.
//  A new sample is taken while the previous result waits in the output
//  register; a stalled output holds the sequencer in its last step.
//  Reset (aresetn low, synchronous) clears control state and loads the
//  register defaults; delay line entries read as zero until first written.
//
module lfo_modulated_delay_chorus #(
    parameter int DELAY_LEN    = chorus_pkg::DELAY_LEN_DEF,
    parameter int SINE_ENTRIES = chorus_pkg::SINE_ENTRIES_DEF,
    parameter int SAMPLE_BITS  = chorus_pkg::SAMPLE_BITS_DEF,
    localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [DATA_W-1:0]                 s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [DATA_W-1:0]                 m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chorus_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [chorus_pkg::APB_DATA_W-1:0] pwdata,
    output logic [chorus_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);

    chorus_pkg::cfg_t  cfg_reg;
    chorus_pkg::stat_t stat;
    chorus_pkg::cmd_t  cmd;
    chorus_pkg::reg_idx_t reg_idx;

    logic                   m_tvalid_reg;
    logic [DATA_W-1:0]      m_tdata_reg;
    logic [SAMPLE_BITS-1:0] result;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = chorus_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wet_percent <= chorus_pkg::WET_RST;
            cfg_reg.base_delay  <= chorus_pkg::BASE_RST;
            cfg_reg.depth       <= chorus_pkg::DEPTH_RST;
            cfg_reg.phase_step  <= chorus_pkg::STEP_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                chorus_pkg::REG_WET:   cfg_reg.wet_percent <= pwdata[chorus_pkg::WET_W-1:0];
                chorus_pkg::REG_BASE:  cfg_reg.base_delay  <= pwdata[chorus_pkg::DLY_CFG_W-1:0];
                chorus_pkg::REG_DEPTH: cfg_reg.depth       <= pwdata[chorus_pkg::DLY_CFG_W-1:0];
                chorus_pkg::REG_STEP:  cfg_reg.phase_step  <= pwdata[chorus_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            chorus_pkg::REG_WET:   prdata = chorus_pkg::APB_DATA_W'(cfg_reg.wet_percent);
            chorus_pkg::REG_BASE:  prdata = chorus_pkg::APB_DATA_W'(cfg_reg.base_delay);
            chorus_pkg::REG_DEPTH: prdata = chorus_pkg::APB_DATA_W'(cfg_reg.depth);
            chorus_pkg::REG_STEP:  prdata = chorus_pkg::APB_DATA_W'(cfg_reg.phase_step);
            default:               prdata = '0;
        endcase
    end

    // Status to the sequencer
    assign stat.in_valid = s_tvalid;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    chorus_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    chorus_dp #(
        .DELAY_LEN    (DELAY_LEN),
        .SINE_ENTRIES (SINE_ENTRIES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
        .sample_out (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= DATA_W'(result);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
